// File: hdl/two_road_traffic_light_sequencer_top_macros.svh
// Assertion macros for the traffic light sequencer top level.
// Expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef TWO_ROAD_TRAFFIC_LIGHT_SEQUENCER_TOP_MACROS_SVH
`define TWO_ROAD_TRAFFIC_LIGHT_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLSEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlseq assertion failed (same cycle)");

// Next-cycle implication, checked outside reset.
`define TLSEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlseq assertion failed (next cycle)");

`endif

// File: hdl/tlseq_pkg.sv
// Shared types and constants for the two-road traffic light sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tlseq_pkg;

  // Tick prescale and fixed yellow time
  localparam logic [2:0] TICKS_PER_SECOND = 3'd5;
  localparam logic [7:0] YELLOW_SECONDS   = 8'd3;

  // Reload values after reset
  localparam logic [7:0] GREEN_RESET = 8'd12;
  localparam logic [7:0] RED_RESET   = 8'd15;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_A_GREEN = 2'd0;
  localparam logic [1:0] REG_A_RED   = 2'd1;
  localparam logic [1:0] REG_B_GREEN = 2'd2;
  localparam logic [1:0] REG_B_RED   = 2'd3;

  // Phase codes, group A
  localparam logic [1:0] PH_A_GREEN  = 2'd0;
  localparam logic [1:0] PH_A_YELLOW = 2'd1;
  localparam logic [1:0] PH_A_RED    = 2'd2;

  // Phase codes, group B
  localparam logic [1:0] PH_B_RED    = 2'd0;
  localparam logic [1:0] PH_B_YELLOW = 2'd1;
  localparam logic [1:0] PH_B_GREEN  = 2'd2;

  // Per-group lamp nibbles. A: {south_red, south_green, north_green, north_red}
  // B: {east_red, east_green, west_green, west_red}
  localparam logic [3:0] LAMP_GO   = 4'b0101;
  localparam logic [3:0] LAMP_STOP = 4'b1010;
  localparam logic [3:0] LAMP_OFF  = 4'b0000;

  typedef struct packed {
    logic [7:0] a_green;
    logic [7:0] a_red;
    logic [7:0] b_green;
    logic [7:0] b_red;
  } reload_t;

  typedef struct packed {
    logic       second_done;
    logic [1:0] phase_a;
    logic [1:0] phase_b;
    logic [7:0] lamps;
  } result_t;

endpackage

// File: hdl/tlseq_cfg.sv
// Reload register file for the traffic light sequencer.
// Depends on tlseq_pkg (register indexes, reset values, reload_t).
`timescale 1ns / 1ps

module tlseq_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [7:0]          wr_data,
  output tlseq_pkg::reload_t  reload
);
  import tlseq_pkg::*;

  reload_t    regs;
  logic [7:0] wr_value;

  // A zero reload would let a counter wrap, so it is stored as one
  assign wr_value = (wr_data == 8'd0) ? 8'd1 : wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.a_green <= GREEN_RESET;
      regs.a_red   <= RED_RESET;
      regs.b_green <= GREEN_RESET;
      regs.b_red   <= RED_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_A_GREEN: regs.a_green <= wr_value;
        REG_A_RED:   regs.a_red   <= wr_value;
        REG_B_GREEN: regs.b_green <= wr_value;
        REG_B_RED:   regs.b_red   <= wr_value;
        default: ;
      endcase
    end
  end

  assign reload = regs;

endmodule

// File: hdl/tlseq_step.sv
// Sequencer state and the per-tick update logic for both road groups.
// Depends on tlseq_pkg (phase codes, lamp patterns, reload_t, result_t).
`timescale 1ns / 1ps

module tlseq_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                tick,
  input  tlseq_pkg::reload_t  reload,
  output tlseq_pkg::result_t  result
);
  import tlseq_pkg::*;

  logic [2:0] tick_count, tick_count_next;
  logic [1:0] a_phase, a_phase_next;
  logic [1:0] b_phase, b_phase_next;
  logic [7:0] a_green_left, a_green_left_next;
  logic [7:0] a_yellow_left, a_yellow_left_next;
  logic [7:0] a_red_left, a_red_left_next;
  logic [7:0] b_red_left, b_red_left_next;
  logic [7:0] b_yellow_left, b_yellow_left_next;
  logic [7:0] b_green_left, b_green_left_next;
  logic [7:0] lamps, lamps_next;
  logic [3:0] lamps_a_next;
  logic [3:0] lamps_b_next;
  logic [2:0] tick_inc;
  logic       second;

  // Prescaler: every TICKS_PER_SECOND-th tick is one second
  always_comb begin
    tick_inc        = tick_count + 3'd1;
    tick_count_next = tick_count;
    second          = 1'b0;
    if (fire && tick) begin
      if (tick_inc == TICKS_PER_SECOND) begin
        tick_count_next = 3'd0;
        second          = 1'b1;
      end else begin
        tick_count_next = tick_inc;
      end
    end
  end

  // Group A: green -> yellow -> red. A count of one expires this second.
  always_comb begin
    a_phase_next       = a_phase;
    a_green_left_next  = a_green_left;
    a_yellow_left_next = a_yellow_left;
    a_red_left_next    = a_red_left;
    lamps_a_next       = lamps[3:0];
    if (second) begin
      case (a_phase)
        PH_A_GREEN: begin
          lamps_a_next = LAMP_GO;
          if (a_green_left == 8'd1) begin
            a_green_left_next = reload.a_green;
            a_phase_next      = PH_A_YELLOW;
          end else begin
            a_green_left_next = a_green_left - 8'd1;
          end
        end
        PH_A_YELLOW: begin
          lamps_a_next = LAMP_OFF;
          if (a_yellow_left == 8'd1) begin
            a_yellow_left_next = YELLOW_SECONDS;
            a_phase_next       = PH_A_RED;
          end else begin
            a_yellow_left_next = a_yellow_left - 8'd1;
          end
        end
        PH_A_RED: begin
          lamps_a_next = LAMP_STOP;
          if (a_red_left == 8'd1) begin
            a_red_left_next = reload.a_red;
            a_phase_next    = PH_A_GREEN;
          end else begin
            a_red_left_next = a_red_left - 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Group B: red -> green -> yellow
  always_comb begin
    b_phase_next       = b_phase;
    b_red_left_next    = b_red_left;
    b_yellow_left_next = b_yellow_left;
    b_green_left_next  = b_green_left;
    lamps_b_next       = lamps[7:4];
    if (second) begin
      case (b_phase)
        PH_B_RED: begin
          lamps_b_next = LAMP_STOP;
          if (b_red_left == 8'd1) begin
            b_red_left_next = reload.b_red;
            b_phase_next    = PH_B_GREEN;
          end else begin
            b_red_left_next = b_red_left - 8'd1;
          end
        end
        PH_B_YELLOW: begin
          lamps_b_next = LAMP_OFF;
          if (b_yellow_left == 8'd1) begin
            b_yellow_left_next = YELLOW_SECONDS;
            b_phase_next       = PH_B_RED;
          end else begin
            b_yellow_left_next = b_yellow_left - 8'd1;
          end
        end
        PH_B_GREEN: begin
          lamps_b_next = LAMP_GO;
          if (b_green_left == 8'd1) begin
            b_green_left_next = reload.b_green;
            b_phase_next      = PH_B_YELLOW;
          end else begin
            b_green_left_next = b_green_left - 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Both lamp groups, group A low
  assign lamps_next = {lamps_b_next, lamps_a_next};

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= 3'd0;
      a_phase       <= PH_A_GREEN;
      b_phase       <= PH_B_RED;
      a_green_left  <= GREEN_RESET;
      a_yellow_left <= YELLOW_SECONDS;
      a_red_left    <= RED_RESET;
      b_red_left    <= RED_RESET;
      b_yellow_left <= YELLOW_SECONDS;
      b_green_left  <= GREEN_RESET;
      lamps         <= 8'd0;
    end else begin
      tick_count    <= tick_count_next;
      a_phase       <= a_phase_next;
      b_phase       <= b_phase_next;
      a_green_left  <= a_green_left_next;
      a_yellow_left <= a_yellow_left_next;
      a_red_left    <= a_red_left_next;
      b_red_left    <= b_red_left_next;
      b_yellow_left <= b_yellow_left_next;
      b_green_left  <= b_green_left_next;
      lamps         <= lamps_next;
    end
  end

  // Result of the beat being processed, taken by the output register
  assign result.second_done = second;
  assign result.phase_a     = a_phase_next;
  assign result.phase_b     = b_phase_next;
  assign result.lamps       = lamps_next;

endmodule

// File: hdl/two_road_traffic_light_sequencer_top.sv
// An accepted tick beat passes the input register, then the result register, to its result beat.
// Throughput: one beat per cycle unless the output is stalled; the step logic is a single pass of small counters.
// in_stall rises only while a beat sits in the input register and the output is stalled.
// Reset (rst, synchronous): pipeline empty, phases A green / B red, counters and
// reloads at 12/15, yellow at 3, lamp register off (out_data is not reset). No clearing pass.
`timescale 1ns / 1ps

module two_road_traffic_light_sequencer_top (
  input  logic       clk,
  input  logic       rst,
  // tick channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       tick,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       second_done,
  output logic [1:0] phase_a,
  output logic [1:0] phase_b,
  output logic       north_red,
  output logic       north_green,
  output logic       south_green,
  output logic       south_red,
  output logic       west_red,
  output logic       west_green,
  output logic       east_green,
  output logic       east_red,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import tlseq_pkg::*;
  `include "two_road_traffic_light_sequencer_top_macros.svh"

  reload_t reload;
  result_t result;
  result_t out_data;
  logic    s1_valid;
  logic    s1_tick;
  logic    out_open;
  logic    fire;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  tlseq_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .reload   (reload)
  );

  // Handshake: the input register moves whenever the result register can load
  assign out_open = !out_valid || !out_stall;
  assign fire     = s1_valid && out_open;
  assign in_stall = s1_valid && !out_open;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_tick <= tick;
    end
  end

  tlseq_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .tick   (s1_tick),
    .reload (reload),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

  assign second_done = out_data.second_done;
  assign phase_a     = out_data.phase_a;
  assign phase_b     = out_data.phase_b;
  assign north_red   = out_data.lamps[0];
  assign north_green = out_data.lamps[1];
  assign south_green = out_data.lamps[2];
  assign south_red   = out_data.lamps[3];
  assign west_red    = out_data.lamps[4];
  assign west_green  = out_data.lamps[5];
  assign east_green  = out_data.lamps[6];
  assign east_red    = out_data.lamps[7];

  // Checks
  `TLSEQ_ASSERT_NEXT(a_fire_gives_result, fire, out_valid)
  `TLSEQ_ASSERT_NOW(a_stall_only_on_back_pressure, in_stall, out_valid && out_stall)
  `TLSEQ_ASSERT_NOW(a_a_lamps_paired, out_valid, (north_red == south_green) && (north_green == south_red))
  `TLSEQ_ASSERT_NOW(a_b_lamps_paired, out_valid, (west_red == east_green) && (west_green == east_red))

endmodule
